// ===== rtl/core/three_axis_trapezoid_step_generator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Step generator assertion macros
// Shared concurrent assertion forms, sampled on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_TRAPEZOID_STEP_GENERATOR_TOP_DEFINES_SVH
`define THREE_AXIS_TRAPEZOID_STEP_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define TASG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step generator assertion failed");

// Next-cycle implication.
`define TASG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step generator assertion failed");

`endif

// ===== rtl/core/tasg_pkg.sv =====
// ----------------------------------------------------------------------------
// Step generator package
// Widths, constants, request and result types shared by the step generator.
// ----------------------------------------------------------------------------
package tasg_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AX_W       = 2;
  localparam int POS_W      = 24;
  localparam int STEPS_W    = 23;
  localparam int DLY_W      = 20;
  localparam int SPD_W      = 20;
  localparam int ACC_W      = 24;
  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 48;
  localparam int SQRT_OUT_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SPD_W-1:0]     DEFAULT_SPEED = 20'd4000;
  localparam logic [ACC_W-1:0]     DEFAULT_ACCEL = 24'd40000;
  localparam logic [DLY_W-1:0]     MAX_DELAY_US  = 20'd20000;
  localparam logic [DIV_NUM_W-1:0] NUM_1E12      = 40'd1000000000000;
  localparam logic [DIV_NUM_W-1:0] NUM_1E6       = 40'd1000000;
  localparam logic [POS_W-1:0]     POS_MAX       = 24'h7FFFFF;
  localparam logic [POS_W-1:0]     POS_MIN       = 24'h800000;
  localparam logic [AX_W-1:0]      LAST_AXIS     = 2'd2;
  localparam logic [AX_W-1:0]      NO_AXIS       = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_EN  = 3'd6;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_SETPOS = 3'd3,
    FUNC_HOME   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_SETPOS,
    OP_HOME,
    OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_AXIS,
    ST_SQ_MUL,
    ST_RAMP_GO,
    ST_RAMP_WAIT,
    ST_CRU_GO,
    ST_CRU_WAIT,
    ST_DLY_SEL,
    ST_DLY_MUL,
    ST_DLY_DIV_GO,
    ST_DLY_DIV_WAIT,
    ST_DLY_SQRT_GO,
    ST_DLY_SQRT_WAIT,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    logic [2:0]              func;
    logic [AX_W-1:0]         axis;
    logic signed [POS_W-1:0] step_count;
    logic [SPD_W-1:0]        max_speed;
    logic [ACC_W-1:0]        accel;
    logic signed [POS_W-1:0] new_position;
  } cmd_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]     step_pulses;
    logic [NUM_AXES-1:0]     directions;
    logic [NUM_AXES-1:0]     busy_axes;
    logic [NUM_AXES-1:0]     done_event;
    logic [NUM_AXES-1:0]     limit_stop;
    logic signed [POS_W-1:0] axis_position;
    logic                    axis_at_limit;
  } res_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_e                op;
    logic [AX_W-1:0]    axis;
    logic               dir;
    logic [STEPS_W-1:0] mag;
    logic [SPD_W-1:0]   speed;
    logic [ACC_W-1:0]   accel;
    logic [POS_W-1:0]   npos;
  } op_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] lim_min;
    logic [NUM_AXES-1:0][POS_W-1:0] lim_max;
    logic                           lim_en;
  } cfg_t;

endpackage

// ===== rtl/core/tasg_front.sv =====
// ----------------------------------------------------------------------------
// Step generator front end
// Decodes requests, applies defaults and saturation, and queues them.
// ----------------------------------------------------------------------------
module tasg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  tasg_pkg::cmd_t  cmd_i,
  output logic            op_valid_o,
  input  logic            op_ready_i,
  output tasg_pkg::op_t   op_o
);

  localparam int PTR_W = $clog2(tasg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tasg_pkg::QUEUE_DEPTH + 1);

  tasg_pkg::op_t            dec_w;
  logic [tasg_pkg::POS_W-1:0] abs_w;
  logic                     ax_ok_w;

  tasg_pkg::op_t            entry_q [tasg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     wr_w, rd_w;

  always_comb begin
    ax_ok_w = (cmd_i.axis != tasg_pkg::NO_AXIS);
    abs_w   = cmd_i.step_count[tasg_pkg::POS_W-1] ? (~cmd_i.step_count + 1'b1)
                                                  : cmd_i.step_count;
    dec_w.axis  = cmd_i.axis;
    dec_w.dir   = ~cmd_i.step_count[tasg_pkg::POS_W-1];
    // Full negative distance saturates to the largest magnitude
    dec_w.mag   = abs_w[tasg_pkg::POS_W-1] ? '1 : abs_w[tasg_pkg::STEPS_W-1:0];
    dec_w.speed = (cmd_i.max_speed == '0) ? tasg_pkg::DEFAULT_SPEED : cmd_i.max_speed;
    dec_w.accel = (cmd_i.accel == '0) ? tasg_pkg::DEFAULT_ACCEL : cmd_i.accel;
    dec_w.npos  = cmd_i.new_position;
    case (cmd_i.func)
      tasg_pkg::FUNC_TICK:   dec_w.op = tasg_pkg::OP_TICK;
      tasg_pkg::FUNC_START:  dec_w.op = (ax_ok_w && cmd_i.step_count != '0) ?
                                        tasg_pkg::OP_START : tasg_pkg::OP_NOP;
      tasg_pkg::FUNC_STOP:   dec_w.op = ax_ok_w ? tasg_pkg::OP_STOP : tasg_pkg::OP_NOP;
      tasg_pkg::FUNC_SETPOS: dec_w.op = ax_ok_w ? tasg_pkg::OP_SETPOS : tasg_pkg::OP_NOP;
      tasg_pkg::FUNC_HOME:   dec_w.op = tasg_pkg::OP_HOME;
      default:               dec_w.op = tasg_pkg::OP_NOP;
    endcase
  end

  assign full       = (cnt_q == CNT_W'(tasg_pkg::QUEUE_DEPTH));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = entry_q[rd_ptr_q];
  assign wr_w       = push && !full;
  assign rd_w       = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = wr_w ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_w ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(wr_w) - CNT_W'(rd_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_w) begin
      entry_q[wr_ptr_q] <= dec_w;
    end
  end

endmodule

// ===== rtl/core/tasg_div.sv =====
// ----------------------------------------------------------------------------
// Step generator divider
// Restoring divider, one quotient bit per cycle, result held until restart.
// ----------------------------------------------------------------------------
module tasg_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tasg_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [tasg_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                             done_o,
  output logic [tasg_pkg::DIV_NUM_W-1:0]   quot_o
);

  localparam int NW    = tasg_pkg::DIV_NUM_W;
  localparam int DW    = tasg_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    num_q, quot_q;
  logic [DW-1:0]    den_q, rem_q, rem_d;
  logic [DW:0]      rem_sh_w, diff_w;
  logic             ge_w;

  always_comb begin
    rem_sh_w = {rem_q, num_q[NW-1]};
    diff_w   = rem_sh_w - {1'b0, den_q};
    ge_w     = (rem_sh_w >= {1'b0, den_q});
    rem_d    = ge_w ? diff_w[DW-1:0] : rem_sh_w[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[NW-2:0], ge_w};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/tasg_sqrt.sv =====
// ----------------------------------------------------------------------------
// Step generator square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tasg_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tasg_pkg::DIV_NUM_W-1:0]   rad_i,
  output logic                             done_o,
  output logic [tasg_pkg::SQRT_OUT_W-1:0]  root_o
);

  localparam int IW    = tasg_pkg::DIV_NUM_W;
  localparam int RW    = tasg_pkg::SQRT_OUT_W;
  localparam int CNT_W = $clog2(RW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IW-1:0]    rad_q;
  logic [RW-1:0]    root_q;
  logic [RW+1:0]    rem_q;
  logic [RW+3:0]    rem_sh_w, trial_w, diff_w;
  logic             ge_w;

  always_comb begin
    rem_sh_w = {rem_q, rad_q[IW-1:IW-2]};
    trial_w  = {2'b00, root_q, 2'b01};
    diff_w   = rem_sh_w - trial_w;
    ge_w     = (rem_sh_w >= trial_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[IW-3:0], 2'b00};
      rem_q  <= ge_w ? diff_w[RW+1:0] : rem_sh_w[RW+1:0];
      root_q <= {root_q[RW-2:0], ge_w};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/tasg_back.sv =====
// ----------------------------------------------------------------------------
// Step generator back end
// Executes requests on the axis state, one axis at a time, with shared units.
// ----------------------------------------------------------------------------
module tasg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  output logic            op_ready_o,
  input  tasg_pkg::op_t   op_i,
  input  tasg_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tasg_pkg::res_t  res_o
);

  localparam int NA = tasg_pkg::NUM_AXES;
  localparam int SW = tasg_pkg::STEPS_W;
  localparam int DW = tasg_pkg::DLY_W;
  localparam int PW = tasg_pkg::POS_W;

  tasg_pkg::back_state_e state_q, state_d;

  logic [NA-1:0]              active_q, dir_q;
  logic [SW-1:0]              target_q [NA];
  logic [SW-1:0]              steps_q  [NA];
  logic [SW-1:0]              ramp_q   [NA];
  logic [DW-1:0]              cruise_q [NA];
  logic [DW-1:0]              delay_q  [NA];
  logic [DW-1:0]              elapsed_q[NA];
  logic [tasg_pkg::ACC_W-1:0] accel_q  [NA];
  logic [PW-1:0]              pos_q    [NA];

  tasg_pkg::op_t              cmd_q;
  logic [tasg_pkg::AX_W-1:0]  ax_q;
  logic [NA-1:0]              pulses_q, dones_q, lims_q;
  logic [SW-1:0]              k_q;
  logic [tasg_pkg::ACC_W+SW-1:0] prod_q;
  logic [tasg_pkg::DIV_NUM_W-1:0] sq_q;

  // Unit hookups
  logic                            div_start_w, div_done_w;
  logic [tasg_pkg::DIV_NUM_W-1:0]  div_num_w, quot_w;
  logic [tasg_pkg::DIV_DEN_W-1:0]  div_den_w;
  logic                            sqrt_start_w, sqrt_done_w;
  logic [tasg_pkg::SQRT_OUT_W-1:0] root_w;

  // Current axis view
  logic          ax_ok_w;
  logic [PW-1:0] pos_rd_w, pos_next_w;
  logic [DW-1:0] el_inc_w, clamp1_w, clamp_w, dly_val_w;
  logic [SW-1:0] steps_inc_w, k_w, half_mag_w;
  logic          step_now_w, fin_w, lim_hit_w, tick_more_w;
  logic          in_ramp_w, in_decel_w, dly_fin_w, axis_adv_w;

  function automatic logic at_lim(input logic [PW-1:0] p, input logic [PW-1:0] lo,
                                  input logic [PW-1:0] hi);
    at_lim = ($signed(p) <= $signed(lo)) || ($signed(p) >= $signed(hi));
  endfunction

  tasg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_w),
    .num_i   (div_num_w),
    .den_i   (div_den_w),
    .done_o  (div_done_w),
    .quot_o  (quot_w)
  );

  tasg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_w),
    .rad_i   (quot_w),
    .done_o  (sqrt_done_w),
    .root_o  (root_w)
  );

  // Per-axis datapath for the axis at ax_q
  always_comb begin
    ax_ok_w     = (ax_q != tasg_pkg::NO_AXIS);
    pos_rd_w    = ax_ok_w ? pos_q[ax_q] : '0;
    el_inc_w    = (elapsed_q[ax_q] == '1) ? elapsed_q[ax_q] : elapsed_q[ax_q] + 1'b1;
    step_now_w  = active_q[ax_q] && (el_inc_w >= delay_q[ax_q]);
    steps_inc_w = steps_q[ax_q] + 1'b1;
    if (dir_q[ax_q]) begin
      pos_next_w = (pos_q[ax_q] == tasg_pkg::POS_MAX) ? pos_q[ax_q] : pos_q[ax_q] + 1'b1;
    end else begin
      pos_next_w = (pos_q[ax_q] == tasg_pkg::POS_MIN) ? pos_q[ax_q] : pos_q[ax_q] - 1'b1;
    end
    fin_w       = (steps_inc_w >= target_q[ax_q]);
    lim_hit_w   = cfg_i.lim_en && at_lim(pos_next_w, cfg_i.lim_min[ax_q],
                                         cfg_i.lim_max[ax_q]);
    tick_more_w = step_now_w && !fin_w && !lim_hit_w;

    in_ramp_w   = (steps_q[ax_q] < ramp_q[ax_q]);
    in_decel_w  = (steps_q[ax_q] >= target_q[ax_q] - ramp_q[ax_q]);
    if (in_ramp_w) begin
      k_w = steps_inc_w;
    end else begin
      k_w = target_q[ax_q] - steps_q[ax_q];
      if (k_w == '0) begin
        k_w = SW'(1);
      end
    end
    half_mag_w  = {1'b0, cmd_q.mag[SW-1:1]};

    clamp1_w = (root_w > tasg_pkg::MAX_DELAY_US) ? tasg_pkg::MAX_DELAY_US : root_w;
    clamp_w  = (clamp1_w < cruise_q[ax_q]) ? cruise_q[ax_q] : clamp1_w;
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_d      = state_q;
    op_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    div_start_w  = 1'b0;
    div_num_w    = tasg_pkg::NUM_1E12;
    div_den_w    = {prod_q, 1'b0};
    sqrt_start_w = 1'b0;
    dly_fin_w    = 1'b0;
    dly_val_w    = clamp_w;
    case (state_q)
      tasg_pkg::ST_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          case (op_i.op)
            tasg_pkg::OP_TICK:  state_d = tasg_pkg::ST_TICK_AXIS;
            tasg_pkg::OP_START: state_d = tasg_pkg::ST_SQ_MUL;
            default:            state_d = tasg_pkg::ST_RESULT;
          endcase
        end
      end
      tasg_pkg::ST_TICK_AXIS: begin
        if (tick_more_w) begin
          state_d = tasg_pkg::ST_DLY_SEL;
        end else if (ax_q == tasg_pkg::LAST_AXIS) begin
          state_d = tasg_pkg::ST_RESULT;
        end
      end
      tasg_pkg::ST_SQ_MUL: state_d = tasg_pkg::ST_RAMP_GO;
      tasg_pkg::ST_RAMP_GO: begin
        div_start_w = 1'b1;
        div_num_w   = sq_q;
        div_den_w   = tasg_pkg::DIV_DEN_W'({cmd_q.accel, 1'b0});
        state_d     = tasg_pkg::ST_RAMP_WAIT;
      end
      tasg_pkg::ST_RAMP_WAIT: begin
        if (div_done_w) begin
          state_d = tasg_pkg::ST_CRU_GO;
        end
      end
      tasg_pkg::ST_CRU_GO: begin
        div_start_w = 1'b1;
        div_num_w   = tasg_pkg::NUM_1E6;
        div_den_w   = tasg_pkg::DIV_DEN_W'(cmd_q.speed);
        state_d     = tasg_pkg::ST_CRU_WAIT;
      end
      tasg_pkg::ST_CRU_WAIT: begin
        if (div_done_w) begin
          state_d = tasg_pkg::ST_DLY_SEL;
        end
      end
      tasg_pkg::ST_DLY_SEL: begin
        if (!in_ramp_w && !in_decel_w) begin
          dly_fin_w = 1'b1;
          dly_val_w = cruise_q[ax_q];
        end else begin
          state_d = tasg_pkg::ST_DLY_MUL;
        end
      end
      tasg_pkg::ST_DLY_MUL: state_d = tasg_pkg::ST_DLY_DIV_GO;
      tasg_pkg::ST_DLY_DIV_GO: begin
        div_start_w = 1'b1;
        state_d     = tasg_pkg::ST_DLY_DIV_WAIT;
      end
      tasg_pkg::ST_DLY_DIV_WAIT: begin
        if (div_done_w) begin
          state_d = tasg_pkg::ST_DLY_SQRT_GO;
        end
      end
      tasg_pkg::ST_DLY_SQRT_GO: begin
        sqrt_start_w = 1'b1;
        state_d      = tasg_pkg::ST_DLY_SQRT_WAIT;
      end
      tasg_pkg::ST_DLY_SQRT_WAIT: begin
        dly_fin_w = sqrt_done_w;
      end
      tasg_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tasg_pkg::ST_IDLE;
        end
      end
      default: state_d = tasg_pkg::ST_IDLE;
    endcase
    if (dly_fin_w) begin
      if (cmd_q.op == tasg_pkg::OP_START || ax_q == tasg_pkg::LAST_AXIS) begin
        state_d = tasg_pkg::ST_RESULT;
      end else begin
        state_d = tasg_pkg::ST_TICK_AXIS;
      end
    end
    axis_adv_w = (state_q == tasg_pkg::ST_TICK_AXIS && !tick_more_w) ||
                 (dly_fin_w && cmd_q.op == tasg_pkg::OP_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tasg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Axis state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      dir_q    <= '0;
      for (int a = 0; a < NA; a++) begin
        target_q[a]  <= '0;
        steps_q[a]   <= '0;
        ramp_q[a]    <= '0;
        cruise_q[a]  <= '0;
        delay_q[a]   <= '0;
        elapsed_q[a] <= '0;
        accel_q[a]   <= '0;
        pos_q[a]     <= '0;
      end
      ax_q     <= '0;
      pulses_q <= '0;
      dones_q  <= '0;
      lims_q   <= '0;
    end else begin
      if (state_q == tasg_pkg::ST_IDLE && op_valid_i) begin
        pulses_q <= '0;
        dones_q  <= '0;
        lims_q   <= '0;
        ax_q     <= (op_i.op == tasg_pkg::OP_TICK) ? '0 : op_i.axis;
        case (op_i.op)
          tasg_pkg::OP_STOP:   active_q[op_i.axis] <= 1'b0;
          tasg_pkg::OP_SETPOS: pos_q[op_i.axis]    <= op_i.npos;
          tasg_pkg::OP_HOME: begin
            active_q <= '0;
            for (int a = 0; a < NA; a++) begin
              pos_q[a] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_q == tasg_pkg::ST_TICK_AXIS && active_q[ax_q]) begin
        if (!step_now_w) begin
          elapsed_q[ax_q] <= el_inc_w;
        end else begin
          pulses_q[ax_q]  <= 1'b1;
          elapsed_q[ax_q] <= '0;
          steps_q[ax_q]   <= steps_inc_w;
          pos_q[ax_q]     <= pos_next_w;
          if (fin_w) begin
            active_q[ax_q] <= 1'b0;
            dones_q[ax_q]  <= 1'b1;
          end else if (lim_hit_w) begin
            active_q[ax_q] <= 1'b0;
            dones_q[ax_q]  <= 1'b1;
            lims_q[ax_q]   <= 1'b1;
          end
        end
      end
      if (state_q == tasg_pkg::ST_RAMP_WAIT && div_done_w) begin
        ramp_q[ax_q] <= (quot_w > tasg_pkg::DIV_NUM_W'(half_mag_w)) ? half_mag_w
                                                                   : quot_w[SW-1:0];
      end
      if (state_q == tasg_pkg::ST_CRU_WAIT && div_done_w) begin
        cruise_q[ax_q]  <= quot_w[DW-1:0];
        target_q[ax_q]  <= cmd_q.mag;
        steps_q[ax_q]   <= '0;
        accel_q[ax_q]   <= cmd_q.accel;
        dir_q[ax_q]     <= cmd_q.dir;
        elapsed_q[ax_q] <= '0;
      end
      if (dly_fin_w) begin
        delay_q[ax_q] <= dly_val_w;
        if (cmd_q.op == tasg_pkg::OP_START) begin
          active_q[ax_q] <= 1'b1;
        end
      end
      if (axis_adv_w) begin
        ax_q <= (ax_q == tasg_pkg::LAST_AXIS) ? cmd_q.axis : ax_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tasg_pkg::ST_IDLE && op_valid_i) begin
      cmd_q <= op_i;
    end
    if (state_q == tasg_pkg::ST_SQ_MUL) begin
      sq_q <= cmd_q.speed * cmd_q.speed;
    end
    if (state_q == tasg_pkg::ST_DLY_SEL) begin
      k_q <= k_w;
    end
    if (state_q == tasg_pkg::ST_DLY_MUL) begin
      prod_q <= accel_q[ax_q] * k_q;
    end
  end

  always_comb begin
    res_o.step_pulses   = pulses_q;
    res_o.directions    = dir_q;
    res_o.busy_axes     = active_q;
    res_o.done_event    = dones_q;
    res_o.limit_stop    = lims_q;
    res_o.axis_position = pos_rd_w;
    res_o.axis_at_limit = ax_ok_w && at_lim(pos_rd_w, cfg_i.lim_min[ax_q],
                                            cfg_i.lim_max[ax_q]);
  end

endmodule

// ===== rtl/core/three_axis_trapezoid_step_generator_top.sv =====
// A stop, set-position or home request goes straight to the back end's result state;
// a tick visits each axis, and each axis that steps outside the cruise phase needs
// one divide and one square root for its new delay, while one in cruise needs neither;
// a start runs a ramp divide and a cruise divide before its first delay.
// The back end takes one request at a time.
// Reset: asynchronous, active low; clears axis state and queues, and loads the default limits.
// ----------------------------------------------------------------------------
// Three-axis trapezoid step generator
// Front decode queue, back sequencer with shared divide/root, result queue.
// ----------------------------------------------------------------------------
`include "three_axis_trapezoid_step_generator_top_defines.svh"

module three_axis_trapezoid_step_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  tasg_pkg::cmd_t                      cmd_i,
  output logic                                empty,
  input  logic                                pop,
  output tasg_pkg::res_t                      res_o,
  input  logic                                cfg_we_i,
  input  logic [tasg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tasg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int PTR_W = $clog2(tasg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tasg_pkg::QUEUE_DEPTH + 1);

  tasg_pkg::op_t  op_w;
  logic           op_valid_w, op_ready_w;
  tasg_pkg::res_t res_w;
  logic           res_valid_w, res_ready_w;
  tasg_pkg::cfg_t cfg_q;

  tasg_pkg::res_t   oq_q [tasg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [CNT_W-1:0] oq_cnt_q;
  logic             oq_wr_w, oq_rd_w;

  // Front: decode and queue requests
  tasg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .cmd_i      (cmd_i),
    .op_valid_o (op_valid_w),
    .op_ready_i (op_ready_w),
    .op_o       (op_w)
  );

  // Back: execute against axis state
  tasg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid_w),
    .op_ready_o  (op_ready_w),
    .op_i        (op_w),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid_w),
    .res_ready_i (res_ready_w),
    .res_o       (res_w)
  );

  // Limit registers; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lim_min <= '0;
      cfg_q.lim_max[0] <= 24'd10400;
      cfg_q.lim_max[1] <= 24'd18400;
      cfg_q.lim_max[2] <= 24'd10400;
      cfg_q.lim_en  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tasg_pkg::CFG_X_MIN:  cfg_q.lim_min[0] <= cfg_wdata_i;
        tasg_pkg::CFG_X_MAX:  cfg_q.lim_max[0] <= cfg_wdata_i;
        tasg_pkg::CFG_Y_MIN:  cfg_q.lim_min[1] <= cfg_wdata_i;
        tasg_pkg::CFG_Y_MAX:  cfg_q.lim_max[1] <= cfg_wdata_i;
        tasg_pkg::CFG_Z_MIN:  cfg_q.lim_min[2] <= cfg_wdata_i;
        tasg_pkg::CFG_Z_MAX:  cfg_q.lim_max[2] <= cfg_wdata_i;
        tasg_pkg::CFG_LIM_EN: cfg_q.lim_en     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Result queue: hold finished results while the back end moves on
  assign res_ready_w = (oq_cnt_q != CNT_W'(tasg_pkg::QUEUE_DEPTH));
  assign oq_wr_w     = res_valid_w && res_ready_w;
  assign empty       = (oq_cnt_q == '0);
  assign oq_rd_w     = pop && !empty;
  assign res_o       = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr_w) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_rd_w) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + CNT_W'(oq_wr_w) - CNT_W'(oq_rd_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr_w) begin
      oq_q[oq_wr_q] <= res_w;
    end
  end

  // A limit stop always also ends the move
  `TASG_ASSERT_NOW(a_lim_in_done, !empty, (res_o.limit_stop & ~res_o.done_event) == '0)
  // An axis whose move ended is no longer busy
  `TASG_ASSERT_NOW(a_done_not_busy, !empty, (res_o.done_event & res_o.busy_axes) == '0)
  // Result queue never overfills
  `TASG_ASSERT_NOW(a_oq_bound, 1'b1, oq_cnt_q <= CNT_W'(tasg_pkg::QUEUE_DEPTH))
  // A lone pop drains exactly one result
  `TASG_ASSERT_NEXT(a_oq_drain, oq_rd_w && !oq_wr_w, oq_cnt_q == $past(oq_cnt_q) - 1'b1)

endmodule

// ===== bench/tb_three_axis_trapezoid_step_generator_top.sv =====
// ----------------------------------------------------------------------------
// Step generator testbench
// Drives requests through the queue ports and checks every result against a
// built-in predictor of the three-axis trapezoid step generator.
// ----------------------------------------------------------------------------
module tb_three_axis_trapezoid_step_generator_top;

  // Codes outside the defined command set
  localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
  localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;
  localparam int unsigned ELAPSED_SAT  = 32'hFFFFF;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned RANDOM_REQS  = 1144;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  tasg_pkg::cmd_t    cmd = '0;
  logic              empty;
  logic              pop = 1'b0;
  tasg_pkg::res_t    res_o;
  logic              cfg_we = 1'b0;
  logic [tasg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [tasg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  three_axis_trapezoid_step_generator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .cmd_i      (cmd),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Axis model: own copy of limits and per-axis motion state
  // --------------------------------------------------------------------------
  int          lim_lo[3];
  int          lim_hi[3];
  bit          lim_on;
  bit          mv_act[3];
  bit          mv_dir[3];
  int unsigned tgt[3];
  int unsigned ndone[3];
  int unsigned ramp_len[3];
  int unsigned cru_dly[3];
  int unsigned cur_dly[3];
  int unsigned elap[3];
  int unsigned mv_acc[3];
  int          pos[3];

  tasg_pkg::res_t expected_results[$];
  int unsigned err_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return int'(r);
  endfunction

  // Step delay for the axis's next step on the trapezoid
  function automatic int unsigned ramp_delay(int a);
    longint unsigned k;
    int unsigned d;
    if (ndone[a] < ramp_len[a]) begin
      k = longint'(ndone[a]) + 1;
    end else if (ndone[a] >= tgt[a] - ramp_len[a]) begin
      k = tgt[a] - ndone[a];
      if (k == 0) k = 1;
    end else begin
      return cru_dly[a];
    end
    d = root_floor(64'd1000000000000 / (2 * longint'(mv_acc[a]) * k));
    if (d > tasg_pkg::MAX_DELAY_US) d = tasg_pkg::MAX_DELAY_US;
    if (d < cru_dly[a]) d = cru_dly[a];
    return d;
  endfunction

  function automatic bit past_limit(int a);
    return pos[a] <= lim_lo[a] || pos[a] >= lim_hi[a];
  endfunction

  function automatic void model_reset();
    lim_lo = '{0, 0, 0};
    lim_hi = '{10400, 18400, 10400};
    lim_on = 1'b1;
    for (int a = 0; a < 3; a++) begin
      mv_act[a] = 0; mv_dir[a] = 0; tgt[a] = 0; ndone[a] = 0; ramp_len[a] = 0;
      cru_dly[a] = 0; cur_dly[a] = 0; elap[a] = 0; mv_acc[a] = 0; pos[a] = 0;
    end
  endfunction

  // Advance the axis model by one request and return the result it yields
  function automatic tasg_pkg::res_t stepgen_predict(tasg_pkg::cmd_t c);
    tasg_pkg::res_t r;
    int ax;
    int mv_len;
    int unsigned spd;
    int unsigned acc;
    longint unsigned mag;
    longint unsigned rmp;
    r = '0;
    ax = int'(c.axis);
    case (c.func)
      tasg_pkg::FUNC_TICK: begin
        for (int a = 0; a < 3; a++) begin
          if (!mv_act[a]) continue;
          if (elap[a] < ELAPSED_SAT) elap[a]++;
          if (elap[a] < cur_dly[a]) continue;
          r.step_pulses[a] = 1'b1;
          ndone[a]++;
          elap[a] = 0;
          if (mv_dir[a]) begin
            if (pos[a] < 8388607) pos[a]++;
          end else begin
            if (pos[a] > -8388608) pos[a]--;
          end
          if (ndone[a] >= tgt[a]) begin
            mv_act[a] = 0;
            r.done_event[a] = 1'b1;
          end else begin
            if (lim_on && past_limit(a)) begin
              mv_act[a] = 0;
              r.done_event[a] = 1'b1;
              r.limit_stop[a] = 1'b1;
            end
            cur_dly[a] = ramp_delay(a);
          end
        end
      end
      tasg_pkg::FUNC_START: begin
        mv_len = c.step_count;
        if (ax < 3 && mv_len != 0) begin
          spd = (c.max_speed == 0) ? tasg_pkg::DEFAULT_SPEED : c.max_speed;
          acc = (c.accel == 0) ? tasg_pkg::DEFAULT_ACCEL : c.accel;
          mag = (mv_len < 0) ? longint'(-longint'(mv_len)) : longint'(mv_len);
          if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
          mv_dir[ax] = mv_len > 0;
          tgt[ax] = int'(mag);
          ndone[ax] = 0;
          mv_acc[ax] = acc;
          rmp = (longint'(spd) * spd) / (2 * longint'(acc));
          if (rmp > mag / 2) rmp = mag / 2;
          ramp_len[ax] = int'(rmp);
          cru_dly[ax] = 1000000 / spd;
          elap[ax] = 0;
          cur_dly[ax] = ramp_delay(ax);
          mv_act[ax] = 1;
        end
      end
      tasg_pkg::FUNC_STOP: if (ax < 3) mv_act[ax] = 0;
      tasg_pkg::FUNC_SETPOS: if (ax < 3) pos[ax] = c.new_position;
      tasg_pkg::FUNC_HOME: begin
        for (int a = 0; a < 3; a++) begin
          mv_act[a] = 0;
          pos[a] = 0;
        end
      end
      default: ;
    endcase
    for (int a = 0; a < 3; a++) begin
      r.directions[a] = mv_dir[a];
      r.busy_axes[a] = mv_act[a];
    end
    if (ax < 3) begin
      r.axis_position = pos[ax][23:0];
      r.axis_at_limit = past_limit(ax);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // --------------------------------------------------------------------------
  int unsigned rx_cyc = 0;

  // Walk through full-rate, coin-flip and one-in-four pop phases
  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 173) % 3)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      default: pop <= (rx_cyc % 4 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    tasg_pkg::res_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, res_o);
        err_cnt++;
      end else begin
        e = expected_results.pop_front();
        if (res_o.step_pulses !== e.step_pulses) begin
          $display("%0t: step_pulses exp %b got %b", $time, e.step_pulses, res_o.step_pulses);
          err_cnt++;
        end
        if (res_o.directions !== e.directions) begin
          $display("%0t: directions exp %b got %b", $time, e.directions, res_o.directions);
          err_cnt++;
        end
        if (res_o.busy_axes !== e.busy_axes) begin
          $display("%0t: busy_axes exp %b got %b", $time, e.busy_axes, res_o.busy_axes);
          err_cnt++;
        end
        if (res_o.done_event !== e.done_event) begin
          $display("%0t: done_event exp %b got %b", $time, e.done_event, res_o.done_event);
          err_cnt++;
        end
        if (res_o.limit_stop !== e.limit_stop) begin
          $display("%0t: limit_stop exp %b got %b", $time, e.limit_stop, res_o.limit_stop);
          err_cnt++;
        end
        if (res_o.axis_position !== e.axis_position) begin
          $display("%0t: axis_position exp %0d got %0d", $time, e.axis_position,
                   res_o.axis_position);
          err_cnt++;
        end
        if (res_o.axis_at_limit !== e.axis_at_limit) begin
          $display("%0t: axis_at_limit exp %b got %b", $time, e.axis_at_limit,
                   res_o.axis_at_limit);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  int unsigned quiet_cyc = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_LIMIT) begin
      $display("tb_three_axis_trapezoid_step_generator_top: errors");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic hold_off(int unsigned n);
    @(negedge clk_i);
    push <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Send one request, with bursts and random gaps in between
  task automatic send_req(tasg_pkg::cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(0, 12));
    end
    burst_left--;
    @(negedge clk_i);
    push <= 1'b1;
    cmd <= c;
    do @(posedge clk_i); while (full);
    expected_results.push_back(stepgen_predict(c));
    req_cnt++;
  endtask

  // Wait until every result is back and the back end has settled
  task automatic drain();
    hold_off(1);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tasg_pkg::CFG_IDX_W-1:0] idx,
                           logic [tasg_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx < tasg_pkg::CFG_LIM_EN) begin
      if (idx[0]) lim_hi[idx >> 1] = $signed(val);
      else lim_lo[idx >> 1] = $signed(val);
    end else if (idx == tasg_pkg::CFG_LIM_EN) begin
      lim_on = val[0];
    end
  endtask

  task automatic set_limits(int lo, int hi, bit en);
    write_reg(tasg_pkg::CFG_X_MIN, tasg_pkg::CFG_DATA_W'(lo));
    write_reg(tasg_pkg::CFG_X_MAX, tasg_pkg::CFG_DATA_W'(hi));
    write_reg(tasg_pkg::CFG_Y_MIN, tasg_pkg::CFG_DATA_W'(lo));
    write_reg(tasg_pkg::CFG_Y_MAX, tasg_pkg::CFG_DATA_W'(hi));
    write_reg(tasg_pkg::CFG_Z_MIN, tasg_pkg::CFG_DATA_W'(lo));
    write_reg(tasg_pkg::CFG_Z_MAX, tasg_pkg::CFG_DATA_W'(hi));
    write_reg(tasg_pkg::CFG_LIM_EN, tasg_pkg::CFG_DATA_W'(en));
  endtask

  function automatic tasg_pkg::cmd_t mk(logic [2:0] f, logic [tasg_pkg::AX_W-1:0] ax,
                                        int mv_len = 0, int unsigned spd = 0,
                                        int unsigned acc = 0, int npos = 0);
    tasg_pkg::cmd_t c;
    c = '0;
    c.func = f;
    c.axis = ax;
    c.step_count = tasg_pkg::POS_W'(mv_len);
    c.max_speed = tasg_pkg::SPD_W'(spd);
    c.accel = tasg_pkg::ACC_W'(acc);
    c.new_position = tasg_pkg::POS_W'(npos);
    return c;
  endfunction

  task automatic ticks(int unsigned n, logic [tasg_pkg::AX_W-1:0] ax);
    repeat (n) send_req(mk(tasg_pkg::FUNC_TICK, ax));
  endtask

  // Every command code, readout of axis 3 and unknown codes
  task automatic test_commands();
    send_req(mk(tasg_pkg::FUNC_TICK, 2'd0));
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd1, 0, 0, 0, 24'h7FFFFF));
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd2, 0, 0, 0, -8388608));
    send_req(mk(tasg_pkg::FUNC_START, 2'd0, 0, 1000, 1000));
    send_req(mk(tasg_pkg::FUNC_START, 2'd0, -8388608, 20'hFFFFF, 24'hFFFFFF));
    send_req(mk(tasg_pkg::FUNC_START, tasg_pkg::NO_AXIS, 5, 1000, 1000, 24'h555555));
    send_req(mk(tasg_pkg::FUNC_SETPOS, tasg_pkg::NO_AXIS, 0, 0, 0, 24'hAAAAAA));
    send_req(mk(tasg_pkg::FUNC_STOP, tasg_pkg::NO_AXIS));
    send_req(mk(tasg_pkg::FUNC_START, 2'd1, 8388607, 0, 0));
    ticks(3, 2'd1);
    send_req(mk(tasg_pkg::FUNC_STOP, 2'd0));
    send_req(mk(FUNC_UNDEF_LO, 2'd1, -1, 20'hFFFFF, 24'hFFFFFF, -1));
    send_req(mk(FUNC_UNDEF_HI, tasg_pkg::NO_AXIS));
    send_req(mk(tasg_pkg::FUNC_HOME, 2'd2));
    send_req(mk(tasg_pkg::FUNC_TICK, tasg_pkg::NO_AXIS));
  endtask

  // Position saturates at both ends with limits off
  task automatic test_saturation();
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd0, 0, 0, 0, 8388607));
    send_req(mk(tasg_pkg::FUNC_START, 2'd0, 1, 1000000, 24'hFFFFFF));
    ticks(180, 2'd0);
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd2, 0, 0, 0, -8388608));
    send_req(mk(tasg_pkg::FUNC_START, 2'd2, -1, 1000000, 24'hFFFFFF));
    ticks(180, 2'd2);
  endtask

  // Stop at a soft limit, and a move that completes right at the limit
  task automatic test_soft_limits();
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd0, 0, 0, 0, 10398));
    send_req(mk(tasg_pkg::FUNC_START, 2'd0, 10, 1000000, 24'hFFFFFF));
    send_req(mk(tasg_pkg::FUNC_SETPOS, 2'd1, 0, 0, 0, 2));
    send_req(mk(tasg_pkg::FUNC_START, 2'd1, -2, 1000000, 24'hFFFFFF));
    ticks(420, 2'd0);
    send_req(mk(tasg_pkg::FUNC_TICK, 2'd1));
  endtask

  // Mostly well-formed moves with random content, plus noise requests
  task automatic test_random(int unsigned n);
    int unsigned goal;
    logic [tasg_pkg::AX_W-1:0] ax;
    tasg_pkg::cmd_t c;
    goal = req_cnt + n;
    while (req_cnt < goal) begin
      ax = tasg_pkg::AX_W'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) begin
        c = tasg_pkg::cmd_t'({$urandom, $urandom, $urandom, $urandom});
        if (c.func == tasg_pkg::FUNC_START && $urandom_range(0, 3) != 0) begin
          c.step_count[23:6] = '0;
        end
        send_req(c);
        continue;
      end
      if ($urandom_range(0, 2) == 0)
        send_req(mk(tasg_pkg::FUNC_SETPOS, ax, 0, 0, 0, $signed($urandom_range(0, 80)) - 20));
      c = mk(tasg_pkg::FUNC_START, ax,
             $signed($urandom_range(1, 40)) * ($urandom_range(0, 1) ? 1 : -1),
             $urandom_range(50000, 1000000), $urandom_range(1000000, 24'hFFFFFF));
      case ($urandom_range(0, 9))
        0: c.max_speed = '0;
        1: c.accel = '0;
        2: c.step_count = tasg_pkg::POS_W'($urandom);
        default: ;
      endcase
      send_req(c);
      repeat ($urandom_range(20, 300)) begin
        case ($urandom_range(0, 40))
          0: send_req(mk(tasg_pkg::FUNC_STOP, tasg_pkg::AX_W'($urandom_range(0, 3))));
          1: send_req(mk(tasg_pkg::FUNC_START, tasg_pkg::AX_W'($urandom_range(0, 2)),
                         $urandom_range(1, 30), $urandom_range(100000, 1000000),
                         $urandom_range(4000000, 24'hFFFFFF)));
          default: send_req(mk(tasg_pkg::FUNC_TICK, tasg_pkg::AX_W'($urandom_range(0, 3))));
        endcase
        if (req_cnt >= goal) break;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_limits(-100, 10400, 1'b1);
    test_commands();
    drain();
    set_limits(-8388608, 8388607, 1'b0);
    test_saturation();
    drain();
    set_limits(0, 10400, 1'b1);
    test_soft_limits();
    drain();
    test_random(RANDOM_REQS / 3);
    drain();
    set_limits(-8388608, 8388607, 1'b0);
    test_random(RANDOM_REQS / 3);
    drain();
    set_limits(-$signed($urandom_range(5, 30)), $urandom_range(5, 30), 1'b1);
    test_random(RANDOM_REQS / 3);
    drain();
    if (err_cnt == 0) begin
      $display("tb_three_axis_trapezoid_step_generator_top: clean");
    end else begin
      $display("tb_three_axis_trapezoid_step_generator_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tasg_pkg.sv
rtl/core/tasg_front.sv
rtl/core/tasg_div.sv
rtl/core/tasg_sqrt.sv
rtl/core/tasg_back.sv
rtl/core/three_axis_trapezoid_step_generator_top.sv
bench/tb_three_axis_trapezoid_step_generator_top.sv
